@@ hdl/adts_pkg.sv @@
// ----------------------------------------------------------------------------
// adts_pkg: shared types and constants for the alarm tone sequencer
// Register indexes, item codes, payload structs and the tone pattern ROM.
// ----------------------------------------------------------------------------
package adts_pkg;

   localparam int PATTERN_STEPS_DEF = 15;
   localparam int ROM_DEPTH         = 16;

   // Configuration register indexes
   localparam logic [1:0] CSR_CHECK_INTERVAL = 2'd0;
   localparam logic [1:0] CSR_STALE_WINDOW   = 2'd1;
   localparam logic [1:0] CSR_RING_DURATION  = 2'd2;

   localparam logic [15:0] CHECK_INTERVAL_RST = 16'd1000;
   localparam logic [15:0] STALE_WINDOW_RST   = 16'd60;
   localparam logic [15:0] RING_DURATION_RST  = 16'd3000;

   // Item kinds
   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_SET   = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   // Event codes
   localparam logic [1:0] EVT_NONE    = 2'd0;
   localparam logic [1:0] EVT_STARTED = 2'd1;
   localparam logic [1:0] EVT_CLEARED = 2'd2;

   localparam logic [15:0] FREQ_HIGH = 16'd988;
   localparam logic [15:0] FREQ_LOW  = 16'd740;
   localparam logic [15:0] GAP_MS    = 16'd100;

   typedef struct packed {
      logic [15:0] check_interval_ms;
      logic [15:0] stale_window_s;
      logic [15:0] ring_duration_ms;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] now_ms;
      logic [31:0] now_seconds;
      logic [31:0] alarm_time;
   } req_type;

   typedef struct packed {
      logic        tone_start;
      logic [15:0] tone_freq_hz;
      logic [15:0] tone_ms;
      logic        speaker_stop;
      logic        volume_max;
      logic [1:0]  event_code;
      logic        stale_cleared;
      logic        ringing;
   } rsp_type;

   typedef struct packed {
      logic [15:0] freq;
      logic [15:0] ms;
   } step_type;

   // Tone/silence pattern. A zero frequency is a silent step.
   function automatic step_type tone_rom(input logic [3:0] idx);
      step_type s;
      case (idx)
         4'd0:    s = '{freq: FREQ_HIGH, ms: 16'd250};
         4'd2:    s = '{freq: FREQ_LOW,  ms: 16'd250};
         4'd4:    s = '{freq: FREQ_HIGH, ms: 16'd250};
         4'd6:    s = '{freq: FREQ_LOW,  ms: 16'd250};
         4'd8:    s = '{freq: FREQ_HIGH, ms: 16'd300};
         4'd10:   s = '{freq: FREQ_LOW,  ms: 16'd300};
         4'd12:   s = '{freq: FREQ_HIGH, ms: 16'd400};
         4'd14:   s = '{freq: FREQ_LOW,  ms: 16'd300};
         default: s = '{freq: 16'd0,     ms: GAP_MS};
      endcase
      return s;
   endfunction

endpackage

@@ hdl/adts_if.sv @@
// ----------------------------------------------------------------------------
// adts_if: channel interfaces of the alarm tone sequencer
// Request, response and register write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface adts_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [31:0] now_ms;
   logic [31:0] now_seconds;
   logic [31:0] alarm_time;

   modport source (output valid, kind, now_ms, now_seconds, alarm_time, input ready);
   modport sink   (input valid, kind, now_ms, now_seconds, alarm_time, output ready);
endinterface

interface adts_rsp_if;
   logic        valid;
   logic        ready;
   logic        tone_start;
   logic [15:0] tone_freq_hz;
   logic [15:0] tone_ms;
   logic        speaker_stop;
   logic        volume_max;
   logic [1:0]  event_code;
   logic        stale_cleared;
   logic        ringing;

   modport source (output valid, tone_start, tone_freq_hz, tone_ms, speaker_stop,
                   volume_max, event_code, stale_cleared, ringing, input ready);
   modport sink   (input valid, tone_start, tone_freq_hz, tone_ms, speaker_stop,
                   volume_max, event_code, stale_cleared, ringing, output ready);
endinterface

interface adts_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  addr;
   logic [15:0] wdata;

   modport source (output valid, addr, wdata, input ready);
   modport sink   (input valid, addr, wdata, output ready);
endinterface

@@ hdl/adts_cfg.sv @@
// ----------------------------------------------------------------------------
// adts_cfg: configuration registers
// Holds the check interval, stale window and ring duration.
// ----------------------------------------------------------------------------
module adts_cfg (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [1:0]       wr_addr,
   input  logic [15:0]      wr_data,
   output adts_pkg::cfg_type cfg
);
   import adts_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_addr)
            CSR_CHECK_INTERVAL: cfg_in.check_interval_ms = wr_data;
            CSR_STALE_WINDOW:   cfg_in.stale_window_s    = wr_data;
            CSR_RING_DURATION:  cfg_in.ring_duration_ms  = wr_data;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.check_interval_ms <= CHECK_INTERVAL_RST;
         cfg_ff.stale_window_s    <= STALE_WINDOW_RST;
         cfg_ff.ring_duration_ms  <= RING_DURATION_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ hdl/adts_engine.sv @@
// ----------------------------------------------------------------------------
// adts_engine: alarm state and per-item decision logic
// Applies one item to the alarm state and forms its result combinationally.
// ----------------------------------------------------------------------------
module adts_engine #(
   parameter int PATTERN_STEPS = adts_pkg::PATTERN_STEPS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  adts_pkg::cfg_type cfg,
   input  adts_pkg::req_type item,
   input  logic              advance,
   output adts_pkg::rsp_type result
);
   import adts_pkg::*;

   localparam int STEP_W = $clog2(PATTERN_STEPS + 1);
   localparam logic [STEP_W-1:0] STEP_COUNT = STEP_W'(PATTERN_STEPS);

   logic [31:0]       deadline_ff, deadline_in;
   logic              fired_ff, fired_in;
   logic              ringing_ff, ringing_in;
   logic              active_ff, active_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [31:0]       step_end_ff, step_end_in;
   logic [31:0]       start_ff, start_in;
   logic [31:0]       next_check_ff, next_check_in;

   logic              check, skip, stale, fire, play, done;
   logic [32:0]       stale_limit;
   logic              ring_eff, act_eff;
   logic [STEP_W-1:0] step_eff, step_next;
   logic [31:0]       end_eff, start_eff, end_diff, check_diff, ring_diff;
   logic [4:0]        step_wide;
   step_type          cur_step;

   always_comb begin
      deadline_in   = deadline_ff;
      fired_in      = fired_ff;
      ringing_in    = ringing_ff;
      active_in     = active_ff;
      step_in       = step_ff;
      step_end_in   = step_end_ff;
      start_in      = start_ff;
      next_check_in = next_check_ff;
      result        = '0;

      // "Reached" means the wrapped difference is non-negative.
      check_diff  = item.now_ms - next_check_ff;
      check       = (deadline_ff != 32'd0) && !fired_ff && !check_diff[31];
      skip        = check && (item.now_seconds == 32'd0);
      stale_limit = {1'b0, deadline_ff} + {17'd0, cfg.stale_window_s};
      stale       = check && !skip && (stale_limit < {1'b0, item.now_seconds});
      fire        = check && !skip && !stale && (item.now_seconds >= deadline_ff);

      // A firing restarts the pattern within the same item.
      ring_eff  = ringing_ff | fire;
      act_eff   = active_ff | fire;
      step_eff  = fire ? '0 : step_ff;
      end_eff   = fire ? item.now_ms : step_end_ff;
      start_eff = fire ? item.now_ms : start_ff;

      step_wide = 5'(step_eff);
      cur_step  = tone_rom(step_wide[3:0]);
      end_diff  = item.now_ms - end_eff;
      play      = !skip && ring_eff && act_eff && (step_eff < STEP_COUNT) && !end_diff[31];
      step_next = step_eff + STEP_W'(play);
      ring_diff = item.now_ms - start_eff;
      done      = !skip && ring_eff && act_eff && (step_next >= STEP_COUNT)
                  && !ring_diff[31] && (ring_diff >= {16'd0, cfg.ring_duration_ms});

      case (item.kind)
         KIND_TICK: begin
            if (check) begin
               next_check_in = item.now_ms + {16'd0, cfg.check_interval_ms};
            end
            if (stale) begin
               deadline_in          = 32'd0;
               result.stale_cleared = 1'b1;
            end
            if (fire) begin
               fired_in          = 1'b1;
               result.volume_max = 1'b1;
               result.event_code = EVT_STARTED;
            end
            ringing_in  = ring_eff;
            active_in   = act_eff & ~done;
            step_in     = play ? step_next : step_eff;
            step_end_in = play ? (item.now_ms + {16'd0, cur_step.ms}) : end_eff;
            start_in    = start_eff;
            if (play && cur_step.freq != 16'd0) begin
               result.tone_start   = 1'b1;
               result.tone_freq_hz = cur_step.freq;
               result.tone_ms      = cur_step.ms;
            end
            result.speaker_stop = (play && cur_step.freq == 16'd0) || done;
         end
         KIND_SET: begin
            deadline_in = item.alarm_time;
            fired_in    = 1'b0;
         end
         KIND_CLEAR: begin
            if (ringing_ff) begin
               result.speaker_stop = 1'b1;
               result.event_code   = EVT_CLEARED;
               ringing_in          = 1'b0;
               active_in           = 1'b0;
            end
            deadline_in = 32'd0;
            fired_in    = 1'b0;
         end
         default: begin
            deadline_in = deadline_ff;
         end
      endcase

      result.ringing = ringing_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         deadline_ff   <= '0;
         fired_ff      <= 1'b0;
         ringing_ff    <= 1'b0;
         active_ff     <= 1'b0;
         step_ff       <= '0;
         step_end_ff   <= '0;
         start_ff      <= '0;
         next_check_ff <= '0;
      end else if (advance) begin
         deadline_ff   <= deadline_in;
         fired_ff      <= fired_in;
         ringing_ff    <= ringing_in;
         active_ff     <= active_in;
         step_ff       <= step_in;
         step_end_ff   <= step_end_in;
         start_ff      <= start_in;
         next_check_ff <= next_check_in;
      end
   end

endmodule

@@ hdl/alarm_deadline_tone_sequencer.sv @@
// ----------------------------------------------------------------------------
// alarm_deadline_tone_sequencer: alarm deadline keeper and tone sequencer
// Checks a wall-clock deadline on tick items and plays a tone pattern.
// ----------------------------------------------------------------------------
// Usage:
// Items (tick, set, clear) arrive on req_chan; every item gives exactly one
// result beat on rsp_chan, in order. Registers are written on csr_chan, which
// is always ready; write only while no item is in flight.
// An accepted beat lands in an input register; when it advances, it is applied to
// the alarm state and its result is written into the output register at the
// same edge, from which the result beat is offered until it is taken. One item
// per cycle is sustained while the receiver takes every result beat; the
// figure is set by the single pass through the decision logic between the
// input and output registers.
// When the receiver stalls, the result is held and the input register takes
// one more beat; after that req_chan.ready drops until the result is taken.
// Reset clears the alarm state, empties both registers and loads the
// register defaults (1000 ms check interval, 60 s stale window, 3000 ms ring).
// ----------------------------------------------------------------------------
module alarm_deadline_tone_sequencer #(
   parameter int PATTERN_STEPS = adts_pkg::PATTERN_STEPS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   adts_req_if.sink    req_chan,
   adts_rsp_if.source  rsp_chan,
   adts_csr_if.sink    csr_chan
);
   import adts_pkg::*;

   cfg_type cfg;
   req_type in_ff;
   logic    in_vld_ff, in_vld_in;
   rsp_type out_ff, result;
   logic    out_vld_ff, out_vld_in;
   logic    advance, take;

   assign advance = in_vld_ff && (!out_vld_ff || rsp_chan.ready);
   assign take    = req_chan.valid && req_chan.ready;

   assign req_chan.ready = !in_vld_ff || advance;
   assign csr_chan.ready = 1'b1;

   assign in_vld_in  = take | (in_vld_ff & ~advance);
   assign out_vld_in = advance | (out_vld_ff & ~rsp_chan.ready);

   adts_cfg u_cfg (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (csr_chan.valid),
      .wr_addr (csr_chan.addr),
      .wr_data (csr_chan.wdata),
      .cfg     (cfg)
   );

   adts_engine #(
      .PATTERN_STEPS (PATTERN_STEPS)
   ) u_engine (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .item    (in_ff),
      .advance (advance),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_ff.kind        <= req_chan.kind;
         in_ff.now_ms      <= req_chan.now_ms;
         in_ff.now_seconds <= req_chan.now_seconds;
         in_ff.alarm_time  <= req_chan.alarm_time;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_chan.valid         = out_vld_ff;
   assign rsp_chan.tone_start    = out_ff.tone_start;
   assign rsp_chan.tone_freq_hz  = out_ff.tone_freq_hz;
   assign rsp_chan.tone_ms       = out_ff.tone_ms;
   assign rsp_chan.speaker_stop  = out_ff.speaker_stop;
   assign rsp_chan.volume_max    = out_ff.volume_max;
   assign rsp_chan.event_code    = out_ff.event_code;
   assign rsp_chan.stale_cleared = out_ff.stale_cleared;
   assign rsp_chan.ringing       = out_ff.ringing;

endmodule

@@ hdl/adts_checker.sv @@
// ----------------------------------------------------------------------------
// adts_checker: port-level checks for the alarm tone sequencer
// Watches the request and result channels and flags inconsistent behaviour.
// ----------------------------------------------------------------------------
module adts_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       tone_start,
   input logic       speaker_stop,
   input logic       volume_max,
   input logic [1:0] event_code,
   input logic       ringing
);
   import adts_pkg::*;

   // A held result beat must stay offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

   // A fresh result must follow an accepted request beat that passed both registers.
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result beat without a request beat");

   // A firing forces volume and leaves the alarm ringing.
   a_fire: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (volume_max || event_code == EVT_STARTED)
         |-> volume_max && event_code == EVT_STARTED && ringing)
      else $error("inconsistent alarm start beat");

   // A clear while ringing stops the speaker and ends ringing, with no tone.
   a_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && event_code == EVT_CLEARED |-> speaker_stop && !ringing && !tone_start)
      else $error("inconsistent alarm clear beat");

endmodule

bind alarm_deadline_tone_sequencer adts_checker u_adts_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .tone_start   (rsp_chan.tone_start),
   .speaker_stop (rsp_chan.speaker_stop),
   .volume_max   (rsp_chan.volume_max),
   .event_code   (rsp_chan.event_code),
   .ringing      (rsp_chan.ringing)
);

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for alarm_deadline_tone_sequencer
// A short directed table opens the run; random alarm sequences follow over
// five register settings and several idling modes. A predictor of the alarm
// and tone state works out each expected result beat that the table does not
// pin, and each is compared field by field with the beat that the block returns.
// ----------------------------------------------------------------------------
module testbench;
   import adts_pkg::*;

   localparam int          PATTERN_LEN      = PATTERN_STEPS_DEF;
   localparam int          PHASES           = 5;
   localparam int          ITEMS_PER_PHASE  = 390;
   localparam int          HOLD_CYCLES      = 250;
   localparam int          CYCLE_LIMIT      = 200000;
   localparam logic [1:0]  KIND_SPARE       = 2'd3;

   typedef struct {
      req_type item;
      logic    pinned;
      rsp_type want;
   } dir_row_type;

   logic clock;
   logic reset;

   adts_req_if req_chan ();
   adts_rsp_if rsp_chan ();
   adts_csr_if csr_chan ();

   alarm_deadline_tone_sequencer dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // Predicted alarm and pattern state, and the register shadow.
   cfg_type     cfg_now     = '{CHECK_INTERVAL_RST, STALE_WINDOW_RST, RING_DURATION_RST};
   logic [31:0] dl_s        = '0;
   logic        fired       = 1'b0;
   logic        ring_on     = 1'b0;
   logic        sounding    = 1'b0;
   logic [3:0]  step_idx    = '0;
   logic [31:0] step_due    = '0;
   logic [31:0] tone_origin = '0;
   logic [31:0] check_at    = '0;

   rsp_type     due_results[$];
   dir_row_type dir_rows[$];

   // Side channel that travels with each request beat: a typed-in result.
   logic        pin_on;
   rsp_type     pin_rsp;

   int          mismatches     = 0;
   int          cycles         = 0;
   int          beats_sent     = 0;
   int          beats_checked  = 0;
   int          phase_items    = 0;
   int          send_idle_pct  = 0;
   int          rcv_stall_pct  = 0;
   int          hold_requests  = 0;
   int          fire_count     = 0;
   int          stale_count    = 0;
   int          clear_count    = 0;
   int          ring_end_count = 0;
   logic [31:0] ms_clock;
   logic [31:0] sec_clock;
   int          ms_frac;

   function automatic logic reached_ms(input logic [31:0] now, input logic [31:0] mark);
      logic [31:0] gap;
      gap = now - mark;
      return ~gap[31];
   endfunction

   function automatic rsp_type alarm_predict(input req_type it);
      rsp_type     o;
      logic        skip_pattern;
      logic [15:0] hz;
      logic [15:0] len;
      logic [31:0] since;
      o = '0;
      skip_pattern = 1'b0;
      case (it.kind)
         KIND_TICK: begin
            if (dl_s != 0 && !fired && reached_ms(it.now_ms, check_at)) begin
               check_at = it.now_ms + {16'd0, cfg_now.check_interval_ms};
               if (it.now_seconds == 0) begin
                  skip_pattern = 1'b1;
               end else if ({1'b0, dl_s} + {17'd0, cfg_now.stale_window_s}
                            < {1'b0, it.now_seconds}) begin
                  dl_s = '0;
                  o.stale_cleared = 1'b1;
               end else if (it.now_seconds >= dl_s) begin
                  fired       = 1'b1;
                  ring_on     = 1'b1;
                  sounding    = 1'b1;
                  tone_origin = it.now_ms;
                  step_idx    = '0;
                  step_due    = it.now_ms;
                  o.volume_max = 1'b1;
                  o.event_code = EVT_STARTED;
               end
            end
            if (!skip_pattern && ring_on && sounding) begin
               if (step_idx < PATTERN_LEN && reached_ms(it.now_ms, step_due)) begin
                  case (step_idx)
                     4'd0, 4'd4: begin hz = FREQ_HIGH; len = 16'd250; end
                     4'd2, 4'd6: begin hz = FREQ_LOW;  len = 16'd250; end
                     4'd8:       begin hz = FREQ_HIGH; len = 16'd300; end
                     4'd10:      begin hz = FREQ_LOW;  len = 16'd300; end
                     4'd12:      begin hz = FREQ_HIGH; len = 16'd400; end
                     4'd14:      begin hz = FREQ_LOW;  len = 16'd300; end
                     default:    begin hz = 16'd0;     len = GAP_MS;  end
                  endcase
                  if (hz == 0) begin
                     o.speaker_stop = 1'b1;
                  end else begin
                     o.tone_start   = 1'b1;
                     o.tone_freq_hz = hz;
                     o.tone_ms      = len;
                  end
                  step_due = it.now_ms + {16'd0, len};
                  step_idx = step_idx + 4'd1;
               end
               if (step_idx >= PATTERN_LEN) begin
                  since = it.now_ms - tone_origin;
                  if (!since[31] && since >= {16'd0, cfg_now.ring_duration_ms}) begin
                     o.speaker_stop = 1'b1;
                     sounding = 1'b0;
                     ring_end_count++;
                  end
               end
            end
         end
         KIND_SET: begin
            dl_s  = it.alarm_time;
            fired = 1'b0;
         end
         KIND_CLEAR: begin
            if (ring_on) begin
               o.speaker_stop = 1'b1;
               o.event_code   = EVT_CLEARED;
               ring_on  = 1'b0;
               sounding = 1'b0;
            end
            dl_s  = '0;
            fired = 1'b0;
         end
         default: ;
      endcase
      o.ringing = ring_on;
      return o;
   endfunction

   task automatic report_mismatch(input string what);
      if (mismatches < 40) $display("MISMATCH cycle %0d: %s", cycles, what);
      mismatches++;
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want) report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
   endtask

   task automatic add_row(input logic [1:0] k, input logic [31:0] ms, input logic [31:0] s,
                          input logic [31:0] at, input logic pin, input rsp_type want);
      dir_row_type row;
      row.item.kind        = k;
      row.item.now_ms      = ms;
      row.item.now_seconds = s;
      row.item.alarm_time  = at;
      row.pinned           = pin;
      row.want             = want;
      dir_rows.push_back(row);
   endtask

   // Offers one beat, with an optional idle gap in front, and waits for it to go.
   task automatic send_item(input logic [1:0] k, input logic [31:0] ms, input logic [31:0] s,
                            input logic [31:0] at, input logic pin, input rsp_type want);
      int gap;
      gap = 0;
      while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.kind        <= k;
      req_chan.now_ms      <= ms;
      req_chan.now_seconds <= s;
      req_chan.alarm_time  <= at;
      pin_on               <= pin;
      pin_rsp              <= want;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      beats_sent++;
      if (k != KIND_SPARE) phase_items++;
   endtask

   // Leaves csr valid high; the caller drops it after the last write.
   task automatic write_csr(input logic [1:0] idx, input logic [15:0] val);
      csr_chan.valid <= 1'b1;
      csr_chan.addr  <= idx;
      csr_chan.wdata <= val;
      do @(posedge clock); while (csr_chan.ready !== 1'b1);
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      while (beats_checked != beats_sent) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic tick_item();
      logic [31:0] dms;
      logic [31:0] s;
      case ($urandom_range(59))
         0, 1, 2: dms = 32'd0;
         3, 4:    dms = $urandom_range(65535, 140000);
         5:       dms = $urandom;
         default: dms = $urandom_range(1, 450);
      endcase
      ms_clock  = ms_clock + dms;
      ms_frac   = ms_frac + (dms % 1000);
      sec_clock = sec_clock + dms / 1000 + ms_frac / 1000;
      ms_frac   = ms_frac % 1000;
      s = ($urandom_range(14) == 0) ? 32'd0 : sec_clock;
      send_item(KIND_TICK, ms_clock, s, $urandom, 1'b0, '0);
   endtask

   // One alarm sequence: arm, a run of ticks, and often a clear at the end; now and then a single random item instead.
   task automatic run_scenario();
      logic [31:0] at;
      int          span;
      int          n;
      if ($urandom_range(99) < 10) begin
         send_item(2'($urandom_range(3)), $urandom, $urandom, $urandom, 1'b0, '0);
      end else begin
         span = int'(cfg_now.stale_window_s) + 3;
         case ($urandom_range(9))
            0:       at = 32'd0;
            1, 2:    at = sec_clock - $urandom_range(0, span);
            default: at = sec_clock + $urandom_range(0, 3);
         endcase
         send_item(KIND_SET, $urandom, $urandom, at, 1'b0, '0);
         n = $urandom_range(4, 30);
         repeat (n) tick_item();
         if ($urandom_range(99) < 55)
            send_item(KIND_CLEAR, $urandom, $urandom, $urandom, 1'b0, '0);
      end
   endtask

   initial begin : clock_gen
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin : watchdog
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : result_sink
      int hold_left;
      int hold_seen;
      hold_left = 0;
      hold_seen = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= rcv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin : scoreboard
      req_type seen;
      rsp_type pred;
      rsp_type got;
      rsp_type want;
      if (!reset) begin
         if (csr_chan.valid && csr_chan.ready) begin
            case (csr_chan.addr)
               CSR_CHECK_INTERVAL: cfg_now.check_interval_ms = csr_chan.wdata;
               CSR_STALE_WINDOW:   cfg_now.stale_window_s    = csr_chan.wdata;
               CSR_RING_DURATION:  cfg_now.ring_duration_ms  = csr_chan.wdata;
               default: ;
            endcase
         end
         if (req_chan.valid && req_chan.ready) begin
            seen.kind        = req_chan.kind;
            seen.now_ms      = req_chan.now_ms;
            seen.now_seconds = req_chan.now_seconds;
            seen.alarm_time  = req_chan.alarm_time;
            pred = alarm_predict(seen);
            if (pred.event_code == EVT_STARTED) fire_count++;
            if (pred.event_code == EVT_CLEARED) clear_count++;
            if (pred.stale_cleared) stale_count++;
            due_results.push_back(pin_on ? pin_rsp : pred);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.tone_start    = rsp_chan.tone_start;
            got.tone_freq_hz  = rsp_chan.tone_freq_hz;
            got.tone_ms       = rsp_chan.tone_ms;
            got.speaker_stop  = rsp_chan.speaker_stop;
            got.volume_max    = rsp_chan.volume_max;
            got.event_code    = rsp_chan.event_code;
            got.stale_cleared = rsp_chan.stale_cleared;
            got.ringing       = rsp_chan.ringing;
            if (due_results.size() == 0) begin
               report_mismatch("result beat arrived with nothing outstanding");
            end else begin
               want = due_results.pop_front();
               check_field("tone_start",    16'(got.tone_start),    16'(want.tone_start));
               check_field("tone_freq_hz",  got.tone_freq_hz,       want.tone_freq_hz);
               check_field("tone_ms",       got.tone_ms,            want.tone_ms);
               check_field("speaker_stop",  16'(got.speaker_stop),  16'(want.speaker_stop));
               check_field("volume_max",    16'(got.volume_max),    16'(want.volume_max));
               check_field("event_code",    16'(got.event_code),    16'(want.event_code));
               check_field("stale_cleared", 16'(got.stale_cleared), 16'(want.stale_cleared));
               check_field("ringing",       16'(got.ringing),       16'(want.ringing));
               beats_checked++;
            end
         end
      end
   end

   initial begin : stimulus
      rsp_type quiet;
      rsp_type stale_flag;
      rsp_type fire_first;
      rsp_type clear_ring;
      quiet = '0;
      stale_flag = '0;
      stale_flag.stale_cleared = 1'b1;
      fire_first = '0;
      fire_first.tone_start   = 1'b1;
      fire_first.tone_freq_hz = 16'd988;
      fire_first.tone_ms      = 16'd250;
      fire_first.volume_max   = 1'b1;
      fire_first.event_code   = EVT_STARTED;
      fire_first.ringing      = 1'b1;
      clear_ring = '0;
      clear_ring.speaker_stop = 1'b1;
      clear_ring.event_code   = EVT_CLEARED;

      reset                <= 1'b1;
      req_chan.valid       <= 1'b0;
      req_chan.kind        <= KIND_TICK;
      req_chan.now_ms      <= '0;
      req_chan.now_seconds <= '0;
      req_chan.alarm_time  <= '0;
      csr_chan.valid       <= 1'b0;
      csr_chan.addr        <= CSR_CHECK_INTERVAL;
      csr_chan.wdata       <= '0;
      pin_on               <= 1'b0;
      pin_rsp              <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed table, register defaults: check every 1000 ms, 60 s stale, 3000 ms ring.
      add_row(KIND_TICK,  32'd0, 32'd0, 32'd0, 1'b1, quiet);
      add_row(KIND_SPARE, '1, '1, '1, 1'b1, quiet);
      add_row(KIND_CLEAR, '1, '1, '1, 1'b1, quiet);
      add_row(KIND_SET,   32'd0, 32'd0, 32'd100, 1'b1, quiet);
      // Unsynced wall clock: the check is used up but nothing else happens.
      add_row(KIND_TICK,  32'd0, 32'd0, 32'd0, 1'b1, quiet);
      add_row(KIND_TICK,  32'd500, 32'd100, 32'd0, 1'b0, quiet);
      add_row(KIND_TICK,  32'd1000, 32'd200, 32'd0, 1'b1, stale_flag);
      add_row(KIND_SET,   32'd0, 32'd0, 32'hFFFF_FFFF, 1'b1, quiet);
      // Deadline at the top of the seconds range: the stale sum must not wrap.
      add_row(KIND_TICK,  32'd2000, 32'hFFFF_FFFF, 32'd0, 1'b1, fire_first);
      add_row(KIND_TICK,  32'd2100, 32'hFFFF_FFFF, 32'd0, 1'b0, quiet);
      add_row(KIND_TICK,  32'd2250, 32'hFFFF_FFFF, 32'd0, 1'b0, quiet);
      add_row(KIND_TICK,  32'd2350, 32'hFFFF_FFFF, 32'd0, 1'b0, quiet);
      add_row(KIND_CLEAR, 32'd2400, 32'd0, 32'd0, 1'b1, clear_ring);
      add_row(KIND_SET,   32'd2500, 32'd0, 32'd50, 1'b0, quiet);
      add_row(KIND_TICK,  32'hFFFF_FF00, 32'd50, 32'd0, 1'b0, quiet);
      add_row(KIND_TICK,  32'h8000_0BB7, 32'd50, 32'd0, 1'b0, quiet);
      add_row(KIND_TICK,  32'hFFFF_FFF0, 32'd51, 32'd0, 1'b0, quiet);
      add_row(KIND_TICK,  32'h0000_0010, 32'd51, 32'd0, 1'b0, quiet);
      add_row(KIND_TICK,  32'h0000_0060, 32'd51, 32'd0, 1'b0, quiet);
      add_row(KIND_SET,   32'h0000_0070, 32'd51, 32'd7, 1'b0, quiet);
      add_row(KIND_TICK,  32'h9000_0000, 32'd1, 32'd0, 1'b0, quiet);
      add_row(KIND_TICK,  32'h9000_03E8, 32'd0, 32'd0, 1'b0, quiet);
      add_row(KIND_CLEAR, 32'h9000_0400, 32'd1, 32'd0, 1'b1, clear_ring);
      foreach (dir_rows[i])
         send_item(dir_rows[i].item.kind, dir_rows[i].item.now_ms,
                   dir_rows[i].item.now_seconds, dir_rows[i].item.alarm_time,
                   dir_rows[i].pinned, dir_rows[i].want);

      for (int ph = 0; ph < PHASES; ph++) begin
         drain();
         case (ph)
            1: begin
               write_csr(CSR_CHECK_INTERVAL, 16'd1);
               write_csr(CSR_STALE_WINDOW,   16'd0);
               write_csr(CSR_RING_DURATION,  16'd0);
               send_idle_pct = 80;
               rcv_stall_pct = 0;
            end
            2: begin
               write_csr(CSR_CHECK_INTERVAL, 16'hFFFF);
               write_csr(CSR_STALE_WINDOW,   16'hFFFF);
               write_csr(CSR_RING_DURATION,  16'hFFFF);
               send_idle_pct = 0;
               rcv_stall_pct = 80;
            end
            3: begin
               // A zero interval lets every tick whose time has not gone back check an armed deadline.
               write_csr(CSR_CHECK_INTERVAL, 16'd0);
               write_csr(CSR_STALE_WINDOW,   16'($urandom_range(0, 16'hFFFF)));
               write_csr(CSR_RING_DURATION,  16'($urandom_range(0, 16'hFFFF)));
               send_idle_pct = 36;
               rcv_stall_pct = 36;
            end
            4: begin
               write_csr(CSR_CHECK_INTERVAL, 16'($urandom_range(1, 3000)));
               write_csr(CSR_STALE_WINDOW,   16'($urandom_range(0, 120)));
               write_csr(CSR_RING_DURATION,  16'($urandom_range(0, 6000)));
               send_idle_pct = 0;
               rcv_stall_pct = 0;
               // Long receiver hold-off while beats keep coming, so the block backs up.
               hold_requests++;
            end
            default: begin
               send_idle_pct = 0;
               rcv_stall_pct = 0;
            end
         endcase
         if (ph != 0) csr_chan.valid <= 1'b0;
         ms_clock  = $urandom;
         sec_clock = $urandom_range(1, 32'hFFFF_FFFF);
         ms_frac   = 0;
         phase_items = 0;
         while (phase_items < ITEMS_PER_PHASE) run_scenario();
      end
      drain();

      $display("Checked %0d result beats from %0d items over %0d register settings.",
               beats_checked, beats_sent, PHASES);
      $display("Alarms fired %0d, stale discards %0d, clears while ringing %0d, ring ends %0d.",
               fire_count, stale_count, clear_count, ring_end_count);
      if (mismatches == 0 && due_results.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
